/* rtl/necir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg
// shared types, constants and helpers of the nec ir frame receiver
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int FRAME_BYTES = 4;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;

  localparam int CNT_W  = 6;
  localparam int WORD_W = 32;
  localparam int TICK_W = 16;

  localparam logic [CNT_W-1:0] FRAME_BITS_CNT = CNT_W'(FRAME_BITS);

  // bits of the word that belong to bytes inside the frame
  localparam logic [WORD_W-1:0] FRAME_MASK =
    ~({WORD_W{1'b1}} >> FRAME_BITS);

  // register indexes
  localparam logic [1:0] REG_LEADER_MIN = 2'd0;
  localparam logic [1:0] REG_LEADER_MAX = 2'd1;
  localparam logic [1:0] REG_ONE_MIN    = 2'd2;
  localparam logic [1:0] REG_ONE_MAX    = 2'd3;

  // reset values
  localparam logic [TICK_W-1:0] LEADER_MIN_RST = 16'd18000;
  localparam logic [TICK_W-1:0] LEADER_MAX_RST = 16'd30000;
  localparam logic [TICK_W-1:0] ONE_MIN_RST    = 16'd3000;
  localparam logic [TICK_W-1:0] ONE_MAX_RST    = 16'd5400;

  // item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TICK_W-1:0] interval;
  } necir_in_t;

  typedef struct packed {
    logic       frame_ready;
    logic       receiving;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } necir_out_t;

  typedef struct packed {
    logic [TICK_W-1:0] leader_min;
    logic [TICK_W-1:0] leader_max;
    logic [TICK_W-1:0] one_min;
    logic [TICK_W-1:0] one_max;
  } necir_cfg_t;

  function automatic logic in_window(input logic [TICK_W-1:0] v,
                                     input logic [TICK_W-1:0] lo,
                                     input logic [TICK_W-1:0] hi);
    in_window = (v >= lo) && (v <= hi);
  endfunction

endpackage

/* rtl/necir_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_cfg
// window registers written through a plain write port
// ----------------------------------------------------------------------------
module necir_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [necir_pkg::TICK_W-1:0] cfg_data,
  output necir_pkg::necir_cfg_t      cfg
);
  import necir_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min <= LEADER_MIN_RST;
      cfg.leader_max <= LEADER_MAX_RST;
      cfg.one_min    <= ONE_MIN_RST;
      cfg.one_max    <= ONE_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEADER_MIN: cfg.leader_min <= cfg_data;
        REG_LEADER_MAX: cfg.leader_max <= cfg_data;
        REG_ONE_MIN:    cfg.one_min    <= cfg_data;
        REG_ONE_MAX:    cfg.one_max    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/necir_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_core
// frame state and the per-item decode step
// ----------------------------------------------------------------------------
module necir_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  necir_pkg::necir_in_t  item,
  input  necir_pkg::necir_cfg_t cfg,
  output necir_pkg::necir_out_t result
);
  import necir_pkg::*;

  logic              held_flag;
  logic              active_flag;
  logic [CNT_W-1:0]  bits_taken;
  logic [WORD_W-1:0] shift_word;

  logic              held_flag_next;
  logic              active_flag_next;
  logic [CNT_W-1:0]  bits_taken_next;
  logic [WORD_W-1:0] shift_word_next;
  logic [WORD_W-1:0] shown_word;
  logic              is_leader;
  logic              is_one;

  assign is_leader = in_window(item.interval, cfg.leader_min, cfg.leader_max);
  assign is_one    = in_window(item.interval, cfg.one_min, cfg.one_max);

  always_comb begin
    held_flag_next   = held_flag;
    active_flag_next = active_flag;
    bits_taken_next  = bits_taken;
    shift_word_next  = shift_word;
    if (item.kind == KIND_ACK) begin
      held_flag_next   = 1'b0;
      active_flag_next = 1'b0;
      bits_taken_next  = '0;
      shift_word_next  = '0;
    end else if (!held_flag) begin
      if (is_leader) begin
        active_flag_next = 1'b1;
        bits_taken_next  = '0;
        shift_word_next  = '0;
      end else if (active_flag) begin
        if (is_one) begin
          shift_word_next = shift_word | ({1'b1, {(WORD_W-1){1'b0}}} >> bits_taken[4:0]);
        end
        bits_taken_next = bits_taken + 1'b1;
        if (bits_taken_next >= FRAME_BITS_CNT) begin
          held_flag_next   = 1'b1;
          active_flag_next = 1'b0;
        end
      end
    end
  end

  // acknowledge shows the frame as it stood before clearing
  assign shown_word = ((item.kind == KIND_ACK) ? shift_word : shift_word_next) & FRAME_MASK;

  always_comb begin
    result.frame_ready = held_flag_next;
    result.receiving   = active_flag_next;
    result.byte0       = shown_word[31:24];
    result.byte1       = shown_word[23:16];
    result.byte2       = shown_word[15:8];
    result.byte3       = shown_word[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag   <= 1'b0;
      active_flag <= 1'b0;
      bits_taken  <= '0;
      shift_word  <= '0;
    end else if (step) begin
      held_flag   <= held_flag_next;
      active_flag <= active_flag_next;
      bits_taken  <= bits_taken_next;
      shift_word  <= shift_word_next;
    end
  end

endmodule

/* rtl/nec_ir_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_receiver_unit
// nec infrared frame receiver fed with falling-edge intervals
// ----------------------------------------------------------------------------
// Each input item is either an edge carrying the tick interval since the
// previous falling edge, or an acknowledge. An interval in the leader window
// starts (or restarts) a frame; later intervals are data bits, 1 inside the
// one window and 0 otherwise, shifted in msb first from byte0 on. After the
// last bit the frame is held and edges are ignored until an acknowledge.
// Every item gives exactly one result item with the flags and bytes after
// the update; an acknowledge reports the bytes as they stood before clearing.
// The unit takes one item per clock cycle while the result channel does not
// stall; an accepted item passes the input register, then the decode step into
// the result register. Window registers should only be written while idle.
// ----------------------------------------------------------------------------
module nec_ir_frame_receiver_unit (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  necir_pkg::necir_in_t         in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output necir_pkg::necir_out_t        out_data,
  // window register write port
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [necir_pkg::TICK_W-1:0] cfg_data
);
  import necir_pkg::*;

  necir_cfg_t cfg;
  necir_in_t  item;
  logic       item_valid;
  necir_out_t result;
  logic       advance;

  // the held item moves on whenever the result register is free or emptying
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  necir_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  necir_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
